/* rtl/s2c_pkg.sv */
// package for the spherical to cartesian converter
// request and result types, cordic lane state and the arctangent constants
// no dependencies
`default_nettype none

package s2c_pkg;

  localparam int CordicWidth = 34;
  localparam int TrigWidth   = 32;

  localparam logic signed [CordicWidth-1:0] GainQ30  = 34'sd652032874;
  localparam logic signed [63:0]            HalfQ30  = 64'sd536870912;

  typedef struct packed {
    logic signed [15:0] radius;
    logic        [15:0] polar_angle;
    logic        [15:0] azimuth_angle;
  } request_t;

  typedef struct packed {
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
  } result_t;

  typedef struct packed {
    logic signed [CordicWidth-1:0] x;
    logic signed [CordicWidth-1:0] y;
    logic signed [CordicWidth-1:0] z;
    logic                          flip;
  } cordic_t;

  typedef struct packed {
    logic               valid;
    cordic_t            theta;
    cordic_t            phi;
    logic signed [15:0] radius;
  } cell_t;

  // arctangent of 2^-step, 2^32 units per turn
  function automatic logic [31:0] atan_step(input int unsigned step);
    logic [31:0] a;
    unique case (step)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

/* rtl/spherical_to_cartesian_core.sv */
// spherical to cartesian point converter, top level
// requests pass through the cordic cells, then the scale stages; one request per cycle while no result is stalled
// one cordic cell per iteration, then four stages of multiply, round and saturate
// a stalled result freezes the whole pipeline; request_stall follows result_stall
// synchronous reset clears all valid bits, payload registers are not reset
// depends on s2c_pkg, s2c_cordic_cell, s2c_scale
`default_nettype none

module spherical_to_cartesian_core #(
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                request_valid,
  output logic               request_stall,
  input  s2c_pkg::request_t  request,
  output logic               result_valid,
  input  wire                result_stall,
  output s2c_pkg::result_t   result
);

  localparam int Drop = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
  localparam logic [15:0] AngleMask = 16'hffff << Drop;

  logic               en;
  s2c_pkg::cell_t     chain [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:1] chain_valid;

  function automatic s2c_pkg::cordic_t fold(input logic [15:0] angle);
    logic [31:0] ph;
    logic        flip;
    logic [31:0] a;
    s2c_pkg::cordic_t c;
    ph     = {angle & AngleMask, 16'h0000};
    flip   = ph[31] ^ ph[30];
    a      = {ph[31] ^ flip, ph[30:0]};
    c.x    = s2c_pkg::GainQ30;
    c.y    = '0;
    c.z    = {{(s2c_pkg::CordicWidth-32){a[31]}}, a};
    c.flip = flip;
    return c;
  endfunction

  assign en            = !(result_valid && result_stall);
  assign request_stall = !en;

  always_comb begin
    chain[0].valid  = request_valid;
    chain[0].theta  = fold(request.polar_angle);
    chain[0].phi    = fold(request.azimuth_angle);
    chain[0].radius = request.radius;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    s2c_cordic_cell #(
      .STEP(i)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  for (genvar i = 1; i <= CORDIC_STEPS; i++) begin : g_valid
    assign chain_valid[i] = chain[i].valid;
  end

  s2c_scale u_scale (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .din    (chain[CORDIC_STEPS]),
    .valid  (result_valid),
    .result (result)
  );

  // requests are held back only by a stalled result
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    request_stall |-> (result_valid && result_stall))
    else $error("request stalled without a stalled result");

  // a frozen pipeline keeps its cell occupancy
  a_chain_frozen: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(chain_valid[CORDIC_STEPS:1]))
    else $error("cordic chain moved while stalled");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!result_valid && chain_valid[CORDIC_STEPS:1] == '0))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

/* rtl/s2c_cordic_cell.sv */
// one rotation-mode cordic iteration for both angles, registered
// depends on s2c_pkg
`default_nettype none

module s2c_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               en,
  input  s2c_pkg::cell_t    din,
  output s2c_pkg::cell_t    dout
);

  localparam logic signed [s2c_pkg::CordicWidth-1:0] Atan =
    $signed({2'b00, s2c_pkg::atan_step(STEP)});

  s2c_pkg::cordic_t theta_next;
  s2c_pkg::cordic_t phi_next;

  function automatic s2c_pkg::cordic_t rotate(input s2c_pkg::cordic_t c);
    logic signed [s2c_pkg::CordicWidth-1:0] x;
    logic signed [s2c_pkg::CordicWidth-1:0] y;
    logic signed [s2c_pkg::CordicWidth-1:0] z;
    logic signed [s2c_pkg::CordicWidth-1:0] dx;
    logic signed [s2c_pkg::CordicWidth-1:0] dy;
    s2c_pkg::cordic_t r;
    x  = c.x;
    y  = c.y;
    z  = c.z;
    dx = y >>> STEP;
    dy = x >>> STEP;
    r.flip = c.flip;
    if (!z[s2c_pkg::CordicWidth-1]) begin
      r.x = x - dx;
      r.y = y + dy;
      r.z = z - Atan;
    end else begin
      r.x = x + dx;
      r.y = y - dy;
      r.z = z + Atan;
    end
    return r;
  endfunction

  always_comb begin
    theta_next = rotate(din.theta);
    phi_next   = rotate(din.phi);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.theta  <= theta_next;
      dout.phi    <= phi_next;
      dout.radius <= din.radius;
    end
  end

endmodule

`default_nettype wire

/* rtl/s2c_scale.sv */
// products of sines and cosines with the radius, rounding and saturation
// four register stages after the cordic chain; depends on s2c_pkg
`default_nettype none

module s2c_scale (
  input  wire                clk,
  input  wire                rst,
  input  wire                en,
  input  s2c_pkg::cell_t     din,
  output logic               valid,
  output s2c_pkg::result_t   result
);

  localparam int TW = s2c_pkg::TrigWidth;

  logic signed [TW-1:0] st;
  logic signed [TW-1:0] ct;
  logic signed [TW-1:0] sp;
  logic signed [TW-1:0] cp;

  logic [2:0]           stage_valid;
  logic signed [63:0]   prod_c;
  logic signed [63:0]   prod_s;
  logic signed [47:0]   prod_z;
  logic signed [15:0]   radius_1;

  logic signed [TW-1:0] px;
  logic signed [TW-1:0] py;
  logic signed [15:0]   z_2;
  logic signed [15:0]   radius_2;

  logic signed [47:0]   mul_x;
  logic signed [47:0]   mul_y;
  logic signed [15:0]   z_3;

  logic signed [63:0]   sum_c;
  logic signed [63:0]   sum_s;
  logic signed [63:0]   sh_c;
  logic signed [63:0]   sh_s;

  function automatic logic signed [15:0] round_sat(input logic signed [47:0] v);
    logic signed [47:0] s;
    logic signed [47:0] q;
    logic signed [15:0] r;
    s = v + 48'sd536870912;
    q = s >>> 30;
    if (q > 48'sd32767) begin
      r = 16'sh7fff;
    end else if (q < -48'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = q[15:0];
    end
    return r;
  endfunction

  // undo the quadrant fold
  always_comb begin
    st = din.theta.flip ? -din.theta.y[TW-1:0] : din.theta.y[TW-1:0];
    ct = din.theta.flip ? -din.theta.x[TW-1:0] : din.theta.x[TW-1:0];
    sp = din.phi.flip   ? -din.phi.y[TW-1:0]   : din.phi.y[TW-1:0];
    cp = din.phi.flip   ? -din.phi.x[TW-1:0]   : din.phi.x[TW-1:0];
  end

  always_comb begin
    sum_c = prod_c + s2c_pkg::HalfQ30;
    sum_s = prod_s + s2c_pkg::HalfQ30;
    sh_c  = sum_c >>> 30;
    sh_s  = sum_s >>> 30;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      valid       <= 1'b0;
    end else if (en) begin
      stage_valid <= {stage_valid[1:0], din.valid};
      valid       <= stage_valid[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_c   <= st * cp;
      prod_s   <= st * sp;
      prod_z   <= din.radius * ct;
      radius_1 <= din.radius;

      px       <= sh_c[TW-1:0];
      py       <= sh_s[TW-1:0];
      z_2      <= round_sat(prod_z);
      radius_2 <= radius_1;

      mul_x    <= radius_2 * px;
      mul_y    <= radius_2 * py;
      z_3      <= z_2;

      result.coord_x <= round_sat(mul_x);
      result.coord_y <= round_sat(mul_y);
      result.coord_z <= z_3;
    end
  end

endmodule

`default_nettype wire

/* sim/s2c_point_checker.sv */
// point checker for the spherical to cartesian converter: watches both channels,
// predicts each point with a cordic of its own and compares every result field
// depends on s2c_pkg for the request and result types
`timescale 1ns / 1ps

module s2c_point_checker #(
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                request_valid,
  input  wire                request_stall,
  input  s2c_pkg::request_t  request,
  input  wire                result_valid,
  input  wire                result_stall,
  input  s2c_pkg::result_t   result,
  output int                 mismatches,
  output int                 waiting
);

  localparam longint UnitGain = 64'sd652032874;
  localparam longint HalfUnit = 64'sd536870912;
  localparam int     TurnSteps = 24;

  s2c_pkg::result_t predicted_points[$];

  initial begin
    mismatches = 0;
    waiting = 0;
  end

  function automatic longint arctan_units(input int step);
    longint a;
    case (step)
      0:  a = 536870912;
      1:  a = 316933406;
      2:  a = 167458907;
      3:  a = 85004756;
      4:  a = 42667331;
      5:  a = 21354465;
      6:  a = 10679838;
      7:  a = 5340245;
      8:  a = 2670163;
      9:  a = 1335087;
      10: a = 667544;
      11: a = 333772;
      12: a = 166886;
      13: a = 83443;
      14: a = 41722;
      15: a = 20861;
      16: a = 10430;
      17: a = 5215;
      18: a = 2608;
      19: a = 1304;
      20: a = 652;
      21: a = 326;
      22: a = 163;
      23: a = 81;
      default: a = 0;
    endcase
    return a;
  endfunction

  function automatic logic [31:0] angle_phase(input logic [15:0] raw);
    logic [63:0] ph;
    if (ANGLE_BITS >= 16) begin
      ph = {48'h0, raw} << (ANGLE_BITS - 16);
    end else begin
      ph = {48'h0, raw} >> (16 - ANGLE_BITS);
    end
    ph = ph << (32 - ANGLE_BITS);
    return ph[31:0];
  endfunction

  function automatic void cordic_trig(input logic [31:0] phase, output longint sin_q30,
                                      output longint cos_q30);
    logic        fold;
    logic [31:0] ph;
    longint      x, y, z, dx, dy;
    fold = (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
    ph = fold ? phase - 32'h8000_0000 : phase;
    x = UnitGain;
    y = 0;
    z = $signed({{32{ph[31]}}, ph});
    for (int i = 0; i < CORDIC_STEPS && i < TurnSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - arctan_units(i);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + arctan_units(i);
      end
    end
    if (fold) begin
      x = -x;
      y = -y;
    end
    sin_q30 = y;
    cos_q30 = x;
  endfunction

  function automatic longint round_q30(input longint v);
    return (v + HalfUnit) >>> 30;
  endfunction

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic s2c_pkg::result_t convert_point(input s2c_pkg::request_t p);
    s2c_pkg::result_t r;
    longint  rad, sin_t, cos_t, sin_p, cos_p, proj_x, proj_y;
    rad = p.radius;
    cordic_trig(angle_phase(p.polar_angle), sin_t, cos_t);
    cordic_trig(angle_phase(p.azimuth_angle), sin_p, cos_p);
    proj_x = round_q30(sin_t * cos_p);
    proj_y = round_q30(sin_t * sin_p);
    r.coord_x = clamp16(round_q30(rad * proj_x));
    r.coord_y = clamp16(round_q30(rad * proj_y));
    r.coord_z = clamp16(round_q30(rad * cos_t));
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic signed [15:0] got,
                             input logic signed [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  always @(posedge clk) begin : watch
    s2c_pkg::result_t want;
    if (rst) begin
      predicted_points.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (predicted_points.size() == 0) begin
          report_mismatch($sformatf("result with no request pending: %0d %0d %0d",
                                    result.coord_x, result.coord_y, result.coord_z));
        end else begin
          want = predicted_points.pop_front();
          check_field("coord_x", result.coord_x, want.coord_x);
          check_field("coord_y", result.coord_y, want.coord_y);
          check_field("coord_z", result.coord_z, want.coord_z);
        end
      end
      if (request_valid && !request_stall) begin
        predicted_points = {predicted_points, convert_point(request)};
      end
    end
    waiting = predicted_points.size();
  end

endmodule

/* sim/testbench.sv */
// top of the spherical to cartesian converter regression: clock, reset, request
// stimulus and result stall patterns, verdict from the point checker
// depends on s2c_pkg, spherical_to_cartesian_core and s2c_point_checker
`timescale 1ns / 1ps

module testbench;

  localparam int AngleBits     = 16;
  localparam int CordicSteps   = 16;
  localparam int Latency       = CordicSteps + 4;
  localparam int LimitCycles   = 200000;
  localparam int HoldOffCycles = 300;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              request_valid = 1'b0;
  s2c_pkg::request_t request = '0;
  logic              result_stall = 1'b0;
  logic              request_stall;
  logic              result_valid;
  s2c_pkg::result_t  result;

  int   mismatches;
  int   waiting;
  int   sender_idle_pct = 0;
  int   stall_pct = 0;
  int   holdoff_left = 0;
  logic holdoff_go = 1'b0;
  logic holdoff_done = 1'b0;
  int   cycle_count = 0;

  spherical_to_cartesian_core #(
    .ANGLE_BITS(AngleBits),
    .CORDIC_STEPS(CordicSteps)
  ) uut (
    .clk(clk),
    .rst(rst),
    .request_valid(request_valid),
    .request_stall(request_stall),
    .request(request),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  s2c_point_checker #(
    .ANGLE_BITS(AngleBits),
    .CORDIC_STEPS(CordicSteps)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .request_valid(request_valid),
    .request_stall(request_stall),
    .request(request),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .mismatches(mismatches),
    .waiting(waiting)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LimitCycles) begin
      $display("spherical_to_cartesian_core regression: fail");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off
  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      result_stall <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_go && !holdoff_done) begin
      result_stall <= 1'b1;
      holdoff_left <= HoldOffCycles;
      holdoff_done <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic s2c_pkg::request_t make_point(input logic [15:0] r,
                                                   input logic [15:0] theta,
                                                   input logic [15:0] phi);
    s2c_pkg::request_t p;
    p.radius = r;
    p.polar_angle = theta;
    p.azimuth_angle = phi;
    return p;
  endfunction

  function automatic logic [15:0] near_quadrant();
    logic [1:0]  q;
    logic [15:0] off;
    q = 2'($urandom_range(3));
    off = 16'($urandom_range(4));
    return {q, 14'h0} + off - 16'd2;
  endfunction

  function automatic s2c_pkg::request_t random_point();
    s2c_pkg::request_t p;
    p.radius = 16'($urandom);
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(4))
        0: p.radius = 16'sh7FFF;
        1: p.radius = 16'sh8000;
        2: p.radius = 16'sh0000;
        3: p.radius = 16'sh0001;
        default: p.radius = 16'shFFFF;
      endcase
    end
    p.polar_angle = ($urandom_range(7) == 0) ? near_quadrant() : 16'($urandom);
    p.azimuth_angle = ($urandom_range(7) == 0) ? near_quadrant() : 16'($urandom);
    return p;
  endfunction

  task automatic send_point(input s2c_pkg::request_t p);
    int gap;
    gap = 0;
    while (gap < 200 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      request_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    request_valid <= 1'b1;
    request <= p;
    @(posedge clk);
    while (request_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // sender pauses until every pending point has come back
  task automatic drain();
    request_valid <= 1'b0;
    @(negedge clk);
    while (waiting != 0) @(negedge clk);
  endtask

  task automatic send_directed();
    logic [15:0] angle;
    send_point(make_point(16'sh8000, 16'h8000, 16'h8000));
    send_point(make_point(16'sh7FFF, 16'h4000, 16'h0000));
    send_point(make_point(16'sh8000, 16'h4000, 16'h0000));
    send_point(make_point(16'sh7FFF, 16'h0000, 16'h0000));
    send_point(make_point(16'sh8000, 16'h0000, 16'h0000));
    send_point(make_point(16'sh0000, 16'hFFFF, 16'hFFFF));
    send_point(make_point(16'sh0001, 16'h2000, 16'h2000));
    send_point(make_point(16'shFFFF, 16'h6000, 16'hA000));
    // octant points on theta, then octant edges minus one on phi
    for (int k = 0; k < 8; k++) begin
      angle = 16'(k) * 16'h2000;
      send_point(make_point(16'sh7FFF, angle, 16'h1234));
    end
    for (int k = 0; k < 8; k++) begin
      angle = 16'(k) * 16'h2000 - 16'd1;
      send_point(make_point(16'sh8000, 16'h4000, angle));
    end
    drain();
  endtask

  task automatic run_phase(input int idle_pct, input int receiver_pct, input int count,
                           input bit hold);
    sender_idle_pct = idle_pct;
    stall_pct <= receiver_pct;
    if (hold) begin
      holdoff_go <= 1'b1;
    end
    repeat (count) send_point(random_point());
    drain();
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_directed();
    run_phase(0, 0, 250, 1'b1);
    run_phase(88, 0, 230, 1'b0);
    run_phase(0, 88, 230, 1'b0);
    run_phase(10, 10, 240, 1'b0);
    repeat (3 * Latency) @(negedge clk);
    if (mismatches == 0) begin
      $display("spherical_to_cartesian_core regression: pass");
    end else begin
      $display("spherical_to_cartesian_core regression: fail");
    end
    $finish;
  end

endmodule
